FILE: rtl/core/bsa_pkg.sv
// Shared codes and types for the bindless slot allocator.
package bsa_pkg;

  localparam int NUM_POOLS = 3;
  localparam int SLOT_W    = 10;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_ASSET = 2'd1,
    ST_FULL     = 2'd2,
    ST_IGNORED  = 2'd3
  } status_t;

  typedef enum logic {
    REQ_ALLOC = 1'b0,
    REQ_FREE  = 1'b1
  } req_t;

  typedef enum logic [1:0] {
    POOL_TEX  = 2'd0,
    POOL_SMP  = 2'd1,
    POOL_COMB = 2'd2,
    POOL_NONE = 2'd3
  } pool_t;

  typedef enum logic {
    S_IDLE,
    S_LOOKUP
  } fsm_t;

endpackage

FILE: rtl/core/bindless_slot_allocator.sv
// Top level of the bindless slot allocator: three LIFO free-list index pools.
//
// Each request (allocate or free) is taken when start is high and busy is low;
// the free-stack and slot-state memories are read at that edge, and the
// following cycle decides, writes the slot state back (and, on a free, the free
// stack) and updates the pool counters. The result is registered at the end of
// that cycle and appears on out_status/out_slot for exactly one cycle with
// out_valid high; the receiver cannot stall it, and busy is low again in that
// same cycle, so a new request is taken only once the last one is through.
// The pace is set by the registered read data of the memories.
// The free-state memory needs no clearing after reset: only states of slots
// below a pool's high-water mark are used; each was written when first issued.
module bindless_slot_allocator #(
  parameter int POOL_SLOTS = 1024
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic       in_req_type,
  input  logic [1:0] in_pool,
  input  logic       in_texture_present,
  input  logic       in_sampler_present,
  input  logic [9:0] in_slot_index,
  output logic       out_valid,
  output logic [1:0] out_status,
  output logic [9:0] out_slot
);

  import bsa_pkg::*;

  localparam int IW    = (POOL_SLOTS > 2) ? $clog2(POOL_SLOTS) : 1;
  localparam int CW    = $clog2(POOL_SLOTS + 1);
  localparam int CMPW  = (CW > SLOT_W) ? CW : SLOT_W;
  localparam int DEPTH = NUM_POOLS * POOL_SLOTS;
  localparam int AW    = $clog2(DEPTH);

  fsm_t            state_r, state_nxt;
  logic [CW-1:0]   hw_r    [NUM_POOLS];
  logic [CW-1:0]   depth_r [NUM_POOLS];
  logic [CW-1:0]   hw_nxt, depth_nxt;
  logic            cnt_we;

  logic            req_r;
  logic [1:0]      pool_r;
  logic            tex_r, smp_r;
  logic [CMPW-1:0] idx_r;

  logic            out_valid_r, out_valid_nxt;
  status_t         out_status_r, status_nxt;
  logic [9:0]      out_slot_r, slot_nxt;

  logic            accept;
  logic [CW-1:0]   depth_in, hw_cur, depth_cur;
  logic [AW-1:0]   base_in, base_cur;
  logic [CMPW-1:0] slot_ext;

  logic            stk_we, bit_we, bit_wdata;
  logic [AW-1:0]   stk_addr, bit_addr;
  logic [IW-1:0]   stk_wdata, stk_rdata, wr_idx;
  logic            bit_rdata;

  assign accept   = start && (state_r == S_IDLE);
  assign busy     = (state_r != S_IDLE);
  assign slot_ext = CMPW'(in_slot_index);

  // Pool base addresses and counter selection; the missing pool reads as empty.
  always_comb begin
    unique case (pool_t'(in_pool))
      POOL_TEX:  begin base_in = '0;                 depth_in = depth_r[0]; end
      POOL_SMP:  begin base_in = AW'(POOL_SLOTS);     depth_in = depth_r[1]; end
      POOL_COMB: begin base_in = AW'(2 * POOL_SLOTS); depth_in = depth_r[2]; end
      default:   begin base_in = '0;                 depth_in = '0;         end
    endcase
    unique case (pool_t'(pool_r))
      POOL_TEX:  begin base_cur = '0;                 hw_cur = hw_r[0]; depth_cur = depth_r[0]; end
      POOL_SMP:  begin base_cur = AW'(POOL_SLOTS);     hw_cur = hw_r[1]; depth_cur = depth_r[1]; end
      POOL_COMB: begin base_cur = AW'(2 * POOL_SLOTS); hw_cur = hw_r[2]; depth_cur = depth_r[2]; end
      default:   begin base_cur = '0;                 hw_cur = '0;      depth_cur = '0;         end
    endcase
  end

  // Next state, decision and memory write-back.
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    status_nxt    = out_status_r;
    slot_nxt      = out_slot_r;
    hw_nxt        = hw_cur;
    depth_nxt     = depth_cur;
    cnt_we        = 1'b0;
    stk_we        = 1'b0;
    bit_we        = 1'b0;
    bit_wdata     = 1'b0;
    wr_idx        = stk_rdata;
    stk_wdata     = idx_r[IW-1:0];
    stk_addr      = base_in + AW'(depth_in) - AW'(1);
    bit_addr      = base_in + AW'(slot_ext[IW-1:0]);

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b1;
        status_nxt    = ST_OK;
        slot_nxt      = '0;
        stk_addr      = base_cur + AW'(depth_cur);
        if (req_r == REQ_ALLOC) begin
          priority if (pool_t'(pool_r) == POOL_NONE) begin
            status_nxt = ST_FULL;
          end else if ((pool_t'(pool_r) != POOL_SMP && !tex_r) ||
                       (pool_t'(pool_r) != POOL_TEX && !smp_r)) begin
            status_nxt = ST_NO_ASSET;
          end else if (depth_cur != '0) begin
            // pop the most recently freed slot
            wr_idx    = stk_rdata;
            depth_nxt = depth_cur - CW'(1);
            cnt_we    = 1'b1;
            bit_we    = 1'b1;
          end else if (hw_cur < CW'(POOL_SLOTS)) begin
            wr_idx = hw_cur[IW-1:0];
            hw_nxt = hw_cur + CW'(1);
            cnt_we = 1'b1;
            bit_we = 1'b1;
          end else begin
            status_nxt = ST_FULL;
          end
          bit_addr  = base_cur + AW'(wr_idx);
          bit_wdata = 1'b0;
          if (bit_we) begin
            slot_nxt = 10'(CMPW'(wr_idx));
          end
        end else begin
          bit_addr  = base_cur + AW'(idx_r[IW-1:0]);
          bit_wdata = 1'b1;
          priority if (pool_t'(pool_r) == POOL_NONE) begin
            status_nxt = ST_IGNORED;
          end else if (idx_r >= CMPW'(hw_cur)) begin
            status_nxt = ST_IGNORED;
          end else if (bit_rdata) begin
            status_nxt = ST_IGNORED;
          end else if (depth_cur >= CW'(POOL_SLOTS)) begin
            status_nxt = ST_IGNORED;
          end else begin
            // mark free and push the index
            bit_we    = 1'b1;
            stk_we    = 1'b1;
            depth_nxt = depth_cur + CW'(1);
            cnt_we    = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_POOLS; i++) begin
        hw_r[i]    <= '0;
        depth_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cnt_we) begin
        hw_r[pool_r]    <= hw_nxt;
        depth_r[pool_r] <= depth_nxt;
      end
    end
  end

  // Hold the request for the lookup cycle.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r  <= in_req_type;
      pool_r <= in_pool;
      tex_r  <= in_texture_present;
      smp_r  <= in_sampler_present;
      idx_r  <= slot_ext;
    end
    out_status_r <= status_nxt;
    out_slot_r   <= slot_nxt;
  end

  bsa_ram #(
    .WIDTH (IW),
    .DEPTH (DEPTH)
  ) u_free_stack (
    .clk   (clk),
    .we    (stk_we),
    .addr  (stk_addr),
    .wdata (stk_wdata),
    .rdata (stk_rdata)
  );

  bsa_ram #(
    .WIDTH (1),
    .DEPTH (DEPTH)
  ) u_slot_state (
    .clk   (clk),
    .we    (bit_we),
    .addr  (bit_addr),
    .wdata (bit_wdata),
    .rdata (bit_rdata)
  );

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_slot   = out_slot_r;

endmodule

FILE: rtl/core/bsa_ram.sv
// Generic single-port RAM with registered read data.
module bsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule
